// ===== sv/rgb_led_blink_controller_unit_assert.svh =====
// Assertion macros shared by the RGB LED blink controller modules.
`ifndef RGB_LED_BLINK_CONTROLLER_UNIT_ASSERT_SVH
`define RGB_LED_BLINK_CONTROLLER_UNIT_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define RGBLED_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define RGBLED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rgbled_pkg.sv =====
// Package with types and constants of the RGB LED blink controller.
package rgbled_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 16;

    localparam logic [TIME_W-1:0] ON_TIME_RESET  = 32'd500;
    localparam logic [TIME_W-1:0] OFF_TIME_RESET = 32'd500;
    localparam logic [TIME_W-1:0] ELAPSED_MAX    = '1;
    localparam logic [2:0]        PINS_DARK      = 3'b111;

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_ON         = 3'd1,
        OP_OFF        = 3'd2,
        OP_BLINK      = 3'd3,
        OP_BLINK_CNT  = 3'd4,
        OP_SET_COLOUR = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_TURN_ON   = 3'd0,
        ST_ON        = 3'd1,
        ST_TURN_OFF  = 3'd2,
        ST_OFF       = 3'd3,
        ST_START_ON  = 3'd4,
        ST_BLINK_ON  = 3'd5,
        ST_START_OFF = 3'd6,
        ST_BLINK_OFF = 3'd7
    } lamp_state_t;

    typedef enum logic {
        CFG_ON_TIME  = 1'b0,
        CFG_OFF_TIME = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [COUNT_W-1:0] count;
        logic [2:0]         colour;
    } step_t;

    typedef struct packed {
        logic [2:0]  pins;
        lamp_state_t mode;
    } result_t;

endpackage

// ===== sv/rgbled_core.sv =====
// State machine and state registers of the RGB LED blink controller.
`include "rgb_led_blink_controller_unit_assert.svh"

module rgbled_core
    import rgbled_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  step_t             step,
    input  logic [TIME_W-1:0] on_time,
    input  logic [TIME_W-1:0] off_time,
    output result_t           result_next
);

    lamp_state_t        mode_reg;
    lamp_state_t        mode_next;
    lamp_state_t        tick_mode;
    logic [TIME_W-1:0]  elapsed_reg;
    logic [TIME_W-1:0]  elapsed_next;
    logic [TIME_W-1:0]  elapsed_inc;
    logic [COUNT_W-1:0] repeats_reg;
    logic [COUNT_W-1:0] repeats_next;
    logic               forever_reg;
    logic               forever_next;
    logic [2:0]         colour_reg;
    logic [2:0]         colour_next;
    logic [2:0]         pins_reg;
    logic [2:0]         pins_next;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        repeats_next = repeats_reg;
        forever_next = forever_reg;
        colour_next  = colour_reg;
        tick_mode    = mode_reg;
        case (step.op)
            OP_TICK:
            begin
                case (mode_reg)
                    ST_TURN_ON:   tick_mode = ST_ON;
                    ST_TURN_OFF:  tick_mode = ST_OFF;
                    ST_START_ON:  tick_mode = ST_BLINK_ON;
                    ST_START_OFF: tick_mode = ST_BLINK_OFF;
                    ST_BLINK_ON:
                    begin
                        if (elapsed_inc > on_time)
                        begin
                            tick_mode = ST_START_OFF;
                        end
                    end
                    ST_BLINK_OFF:
                    begin
                        if (elapsed_inc > off_time)
                        begin
                            if (forever_reg)
                            begin
                                tick_mode = ST_START_ON;
                            end
                            else if (repeats_reg != '0)
                            begin
                                repeats_next = repeats_reg - 1'b1;
                                tick_mode    = ST_START_ON;
                            end
                        end
                    end
                    default: tick_mode = mode_reg;
                endcase
                if (tick_mode != mode_reg)
                begin
                    mode_next    = tick_mode;
                    elapsed_next = '0;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            OP_ON:
            begin
                mode_next    = ST_TURN_ON;
                elapsed_next = '0;
            end
            OP_OFF:
            begin
                mode_next    = ST_TURN_OFF;
                elapsed_next = '0;
            end
            OP_BLINK:
            begin
                forever_next = 1'b1;
                mode_next    = ST_START_ON;
                elapsed_next = '0;
            end
            OP_BLINK_CNT:
            begin
                forever_next = 1'b0;
                repeats_next = step.count;
                mode_next    = ST_START_ON;
                elapsed_next = '0;
            end
            OP_SET_COLOUR: colour_next = step.colour;
            default:       mode_next = mode_reg;
        endcase
    end

    always_comb
    begin
        pins_next = pins_reg;
        case (step.op)
            OP_TICK:
            begin
                case (mode_reg)
                    ST_TURN_ON, ST_START_ON:   pins_next = ~colour_reg;
                    ST_TURN_OFF, ST_START_OFF: pins_next = PINS_DARK;
                    default:                   pins_next = pins_reg;
                endcase
            end
            OP_SET_COLOUR:
            begin
                if (mode_reg == ST_TURN_ON || mode_reg == ST_ON ||
                    mode_reg == ST_START_ON || mode_reg == ST_BLINK_ON)
                begin
                    pins_next = ~step.colour;
                end
            end
            default: pins_next = pins_reg;
        endcase
    end

    assign result_next.pins = pins_next;
    assign result_next.mode = mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ST_OFF;
            elapsed_reg <= '0;
            repeats_reg <= '0;
            forever_reg <= 1'b0;
            colour_reg  <= '0;
            pins_reg    <= PINS_DARK;
        end
        else if (step_en)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            repeats_reg <= repeats_next;
            forever_reg <= forever_next;
            colour_reg  <= colour_next;
            pins_reg    <= pins_next;
        end
    end

    `RGBLED_ASSERT_IMPLY(a_off_dark, mode_reg == ST_OFF, pins_reg == PINS_DARK, "lit in off state")
    `RGBLED_ASSERT_IMPLY(a_blink_off_dark, mode_reg == ST_BLINK_OFF, pins_reg == PINS_DARK, "lit in blink off")
    `RGBLED_ASSERT_NEXT(a_turn_on_tick, step_en && step.op == OP_TICK && mode_reg == ST_TURN_ON, mode_reg == ST_ON && elapsed_reg == '0, "turn on did not settle")

endmodule

// ===== sv/rgb_led_blink_controller_unit.sv =====
// Top level of the RGB LED blink controller: handshake stages and config registers.
//
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_stall  op, count, want_red, want_green, want_blue
// out       source     out_valid/out_stall red_pin, green_pin, blue_pin, lamp_state
// cfg       sink       cfg_we             cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled.
// The input register feeds the state update, whose result lands in the output register.
// Reset puts the lamp in the off state, dark, with both times at 500 ticks.
// A stalled output holds its result; the input stalls only when both stages are full
// and the output is stalled.
`include "rgb_led_blink_controller_unit_assert.svh"

module rgb_led_blink_controller_unit
    import rgbled_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [COUNT_W-1:0] count,
    input  logic               want_red,
    input  logic               want_green,
    input  logic               want_blue,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               red_pin,
    output logic               green_pin,
    output logic               blue_pin,
    output logic [2:0]         lamp_state,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [TIME_W-1:0]  cfg_data
);

    logic              stage_valid_reg;
    logic              stage_valid_next;
    step_t             stage_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    result_t           out_reg;
    result_t           core_result;
    logic              out_free;
    logic              advance;
    logic              in_take;
    logic [TIME_W-1:0] on_time_reg;
    logic [TIME_W-1:0] off_time_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = stage_valid_reg && out_free;
    assign in_stall = stage_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign stage_valid_next = in_take || (stage_valid_reg && !advance);
    assign out_valid_next   = advance || (out_valid_reg && out_stall);

    rgbled_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .step        (stage_reg),
        .on_time     (on_time_reg),
        .off_time    (off_time_reg),
        .result_next (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg  <= ON_TIME_RESET;
            off_time_reg <= OFF_TIME_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ON_TIME:  on_time_reg  <= cfg_data;
                CFG_OFF_TIME: off_time_reg <= cfg_data;
                default:      on_time_reg  <= on_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_reg.op     <= op;
            stage_reg.count  <= count;
            stage_reg.colour <= {want_blue, want_green, want_red};
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_pin    = out_reg.pins[0];
    assign green_pin  = out_reg.pins[1];
    assign blue_pin   = out_reg.pins[2];
    assign lamp_state = out_reg.mode;

    `RGBLED_ASSERT_IMPLY(a_stall_full, in_stall, stage_valid_reg && out_valid_reg && out_stall, "stall with free slot")
    `RGBLED_ASSERT_NEXT(a_advance_out, advance, out_valid_reg, "advanced transaction lost")
    `RGBLED_ASSERT_NEXT(a_drain, out_valid_reg && !out_stall && !advance, !out_valid_reg, "transaction repeated")

endmodule
